@@ rtl/itcs_pkg.sv @@
`default_nettype none

package itcs_pkg;

    // Event codes carried in the mode field
    localparam logic [2:0] MODE_PIO       = 3'd0;
    localparam logic [2:0] MODE_MWDMA     = 3'd1;
    localparam logic [2:0] MODE_UDMA      = 3'd2;
    localparam logic [2:0] MODE_DMA_START = 3'd3;
    localparam logic [2:0] MODE_DMA_END   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_CHANNEL   = 2'd0;
    localparam logic [1:0] CFG_REV10     = 2'd1;
    localparam logic [1:0] CFG_CTRL_INIT = 2'd2;

    // Clock wants
    localparam logic [1:0] WANT_66  = 2'd0;
    localparam logic [1:0] WANT_50  = 2'd1;
    localparam logic [1:0] WANT_ANY = 2'd2;

    // Priorities
    localparam logic [1:0] PRIO_NONE  = 2'd0;
    localparam logic [1:0] PRIO_PIO   = 2'd1;
    localparam logic [1:0] PRIO_MWDMA = 2'd2;
    localparam logic [1:0] PRIO_UDMA  = 2'd3;

    // Config space addresses and masks
    localparam logic [6:0]  ADDR_CTRL      = 7'h50;
    localparam logic [6:0]  ADDR_PIO_BASE  = 7'h54;
    localparam logic [6:0]  ADDR_UDMA_BASE = 7'h56;
    localparam logic [7:0]  CH1_UDMA_BITS  = 8'h60;
    localparam logic [7:0]  CH0_UDMA_BITS  = 8'h18;
    localparam logic [7:0]  CH1_UDMA_KEEP  = 8'h9F;
    localparam logic [7:0]  CH0_UDMA_KEEP  = 8'hE7;
    localparam logic [15:0] UD_FAST_MASK   = 16'h8080;

    localparam int unsigned LIST_DEPTH = 10;
    localparam int unsigned IN_W       = 16;
    localparam int unsigned OUT_W      = 16;

    typedef struct packed {
        logic [2:0] pair_best_pio;
        logic       pair_present;
        logic [2:0] level;
        logic       unit;
        logic [2:0] mode;
    } event_t;

    typedef struct packed {
        logic [7:0] data;
        logic [6:0] addr;
    } wr_t;

    function automatic logic [15:0] pio_word(input logic [2:0] lv);
        logic [15:0] w;
        case (lv)
            3'd0:    w = 16'hAA88;
            3'd1:    w = 16'hA382;
            3'd2:    w = 16'hA181;
            3'd3:    w = 16'h3332;
            default: w = 16'h3121;
        endcase
        return w;
    endfunction

    function automatic logic [1:0] pio_clk_want(input logic [2:0] lv);
        return (lv >= 3'd4) ? WANT_ANY : WANT_66;
    endfunction

    function automatic logic [15:0] mw_word(input logic [2:0] lv);
        logic [15:0] w;
        case (lv)
            3'd0:    w = 16'h8866;
            3'd1:    w = 16'h3222;
            default: w = 16'h3121;
        endcase
        return w;
    endfunction

    function automatic logic [1:0] mw_want(input logic [2:0] lv);
        return (lv == 3'd1) ? WANT_66 : WANT_ANY;
    endfunction

    // UDMA 5 and above also carry the fast-mode bits in both bytes
    function automatic logic [15:0] ud_word(input logic [2:0] lv);
        logic [15:0] w;
        case (lv)
            3'd0:    w = 16'h4433;
            3'd1:    w = 16'h4231;
            3'd2:    w = 16'h3121;
            3'd3:    w = 16'h2121;
            3'd4:    w = 16'h1111;
            3'd5:    w = 16'h2211 | UD_FAST_MASK;
            default: w = 16'h1111 | UD_FAST_MASK;
        endcase
        return w;
    endfunction

    function automatic logic [1:0] ud_want(input logic [2:0] lv);
        logic [1:0] w;
        case (lv)
            3'd1:    w = WANT_50;
            3'd3:    w = WANT_66;
            3'd4:    w = WANT_66;
            3'd5:    w = WANT_50;
            3'd6:    w = WANT_66;
            3'd7:    w = WANT_66;
            default: w = WANT_ANY;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] pick_byte(input logic [15:0] t, input logic c50);
        return c50 ? t[7:0] : t[15:8];
    endfunction

endpackage

`default_nettype wire

@@ rtl/ide_timing_clock_selector_unit.sv @@
`default_nettype none

// Timing and clock selector for one channel of a two-drive parallel ATA port.
// Each input item is an event for one drive (set PIO, set MWDMA, set UDMA,
// DMA start, DMA end). The block looks up the timing word and clock want for
// the requested mode, records the drive's priority, arbitrates the channel
// clock between 66 and 50 MHz, and emits the config byte writes the event
// causes as a run of output items, the final one marked by m_tlast. Timing
// bytes are taken from the high half of a word at 66 MHz and the low half at
// 50 MHz. An accepted item is held in an input register; its whole effect on
// the state and its list of writes (up to ten) are worked out combinationally
// from there and loaded into a write list once the list is free. The list
// then drains at one output item per cycle while m_tready is high. The next
// item is loaded as the final write of the previous one leaves, so the block
// can take in a new event while the writes of the last one are still draining.
// Configuration is taken on the cfg channel, which is always ready; a write
// to ctrl_init reloads the control byte and the clock select bit of the
// served channel.
module ide_timing_clock_selector_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Events in
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // [2:0] mode, [3] unit, [6:4] level, [7] pair_present, [10:8] pair_best_pio
    input  wire logic [itcs_pkg::IN_W-1:0]   s_tdata,
    // Config writes out
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [6:0] write_addr, [14:7] write_data
    output logic [itcs_pkg::OUT_W-1:0]       m_tdata,
    output logic                             m_tlast,
    // Configuration
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [7:0]                  cfg_data
);

    import itcs_pkg::*;

    // Input register
    event_t     in_reg;
    logic       in_valid_reg;

    // Configuration
    logic       ch_reg;
    logic       rev_reg;

    // Channel and per-unit state
    logic [7:0]  ctrl_reg, ctrl_next;
    logic        clk50_reg, clk50_next;
    logic [3:0]  wants_reg [2];
    logic [3:0]  wants_next [2];
    logic [15:0] pio_reg [2];
    logic [15:0] pio_next [2];
    logic [15:0] mw_reg [2];
    logic [15:0] mw_next [2];
    logic [15:0] ud_reg [2];
    logic [15:0] ud_next [2];

    // Write list: rd_reg walks up to n_reg
    wr_t        lst_reg [LIST_DEPTH];
    wr_t        lst_next [LIST_DEPTH];
    logic [3:0] n_reg, n_next;
    logic [3:0] rd_reg;

    logic       list_empty;
    logic       list_last;
    logic       pop;
    logic       load;

    assign list_empty = (rd_reg == n_reg);
    assign list_last  = (rd_reg == n_reg - 4'd1);
    assign m_tvalid   = !list_empty;
    assign m_tdata    = {1'b0, lst_reg[rd_reg]};
    assign m_tlast    = list_last;
    assign pop        = m_tvalid && m_tready;
    assign load       = in_valid_reg && (list_empty || (pop && list_last));
    assign s_tready   = !in_valid_reg || load;
    assign cfg_ready  = 1'b1;

    // Work out the state update and the write list for the held event
    always_comb
    begin
        logic       u;
        logic [2:0] lv_p;
        logic [2:0] pb;
        logic [2:0] lv_m;
        logic [2:0] lv_u;
        logic [6:0] pio_addr;
        logic [6:0] ud_base;
        logic [7:0] b;
        logic [7:0] clk_bit;
        logic [1:0] p0;
        logic [1:0] p1;
        logic [1:0] want;
        logic [1:0] alt;
        logic       do_arb;
        logic [3:0] cnt;

        u        = in_reg.unit;
        pio_addr = ADDR_PIO_BASE + {4'b0, ch_reg, 2'b00};
        ud_base  = ADDR_UDMA_BASE + {4'b0, ch_reg, 2'b00};
        clk_bit  = ch_reg ? 8'h04 : 8'h02;

        lv_p = (in_reg.level > 3'd4) ? 3'd4 : in_reg.level;
        pb   = (in_reg.pair_best_pio > 3'd4) ? 3'd4 : in_reg.pair_best_pio;
        if (in_reg.pair_present && (pb < lv_p))
        begin
            lv_p = pb;
        end
        lv_m = (in_reg.level > 3'd2) ? 3'd2 : in_reg.level;
        lv_u = (in_reg.level > 3'd6) ? 3'd6 : in_reg.level;

        wants_next = wants_reg;
        pio_next   = pio_reg;
        mw_next    = mw_reg;
        ud_next    = ud_reg;
        ctrl_next  = ctrl_reg;
        clk50_next = clk50_reg;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            lst_next[i] = '0;
        end
        cnt    = 4'd0;
        do_arb = 1'b0;
        b      = 8'd0;

        case (in_reg.mode)
            MODE_PIO:
            begin
                wants_next[u] = {PRIO_PIO, pio_clk_want(lv_p)};
                pio_next[u]   = pio_word(lv_p);
                do_arb        = 1'b1;
            end
            MODE_MWDMA:
            begin
                wants_next[u] = {PRIO_MWDMA, mw_want(lv_m)};
                mw_next[u]    = mw_word(lv_m);
                ud_next[u]    = 16'd0;
                if (rev_reg)
                begin
                    ctrl_next = ctrl_next | (ch_reg ? CH1_UDMA_BITS : CH0_UDMA_BITS);
                end
                else
                begin
                    ctrl_next = ctrl_next | (8'h08 << {ch_reg, u});
                end
                lst_next[cnt] = '{data: ctrl_next, addr: ADDR_CTRL};
                cnt           = cnt + 4'd1;
                do_arb        = 1'b1;
            end
            MODE_UDMA:
            begin
                wants_next[u] = {PRIO_UDMA, ud_want(lv_u)};
                mw_next[u]    = 16'd0;
                ud_next[u]    = ud_word(lv_u);
                if (rev_reg)
                begin
                    ctrl_next = ctrl_next & (ch_reg ? CH1_UDMA_KEEP : CH0_UDMA_KEEP);
                end
                else
                begin
                    ctrl_next = ctrl_next & ~(8'h08 << {ch_reg, u});
                end
                lst_next[cnt] = '{data: ctrl_next, addr: ADDR_CTRL};
                cnt           = cnt + 4'd1;
                do_arb        = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Clock arbitration: the higher priority unit wins, unit 1 on a tie,
        // and a want of "any" defers to the other unit.
        p0 = wants_next[0][3:2];
        p1 = wants_next[1][3:2];
        if (p0 > p1)
        begin
            want = wants_next[0][1:0];
            alt  = wants_next[1][1:0];
        end
        else
        begin
            want = wants_next[1][1:0];
            alt  = wants_next[0][1:0];
        end
        if (want >= WANT_ANY)
        begin
            want = alt;
        end
        if (do_arb && (want < WANT_ANY) && (want[0] != clk50_reg))
        begin
            clk50_next = want[0];
            ctrl_next  = want[0] ? (ctrl_next | clk_bit) : (ctrl_next & ~clk_bit);
            lst_next[cnt] = '{data: ctrl_next, addr: ADDR_CTRL};
            cnt           = cnt + 4'd1;
            // The other drive first, then this one, each UDMA then PIO
            if (in_reg.pair_present && (ud_next[~u] != 16'd0))
            begin
                b = pick_byte(ud_next[~u], clk50_next);
                if (rev_reg)
                begin
                    lst_next[cnt] = '{data: b, addr: ud_base};
                    cnt           = cnt + 4'd1;
                    lst_next[cnt] = '{data: b, addr: ud_base + 7'd1};
                    cnt           = cnt + 4'd1;
                end
                else
                begin
                    lst_next[cnt] = '{data: b, addr: ud_base + {6'd0, ~u}};
                    cnt           = cnt + 4'd1;
                end
                lst_next[cnt] = '{data: pick_byte(pio_next[~u], clk50_next), addr: pio_addr};
                cnt           = cnt + 4'd1;
            end
            if (ud_next[u] != 16'd0)
            begin
                b = pick_byte(ud_next[u], clk50_next);
                if (rev_reg)
                begin
                    lst_next[cnt] = '{data: b, addr: ud_base};
                    cnt           = cnt + 4'd1;
                    lst_next[cnt] = '{data: b, addr: ud_base + 7'd1};
                    cnt           = cnt + 4'd1;
                end
                else
                begin
                    lst_next[cnt] = '{data: b, addr: ud_base + {6'd0, u}};
                    cnt           = cnt + 4'd1;
                end
                lst_next[cnt] = '{data: pick_byte(pio_next[u], clk50_next), addr: pio_addr};
                cnt           = cnt + 4'd1;
            end
        end

        // Writes that close the event
        case (in_reg.mode)
            MODE_PIO:
            begin
                lst_next[cnt] = '{data: pick_byte(pio_next[u], clk50_next), addr: pio_addr};
                cnt           = cnt + 4'd1;
            end
            MODE_UDMA:
            begin
                b = pick_byte(ud_next[u], clk50_next);
                if (rev_reg)
                begin
                    lst_next[cnt] = '{data: b, addr: ud_base};
                    cnt           = cnt + 4'd1;
                    lst_next[cnt] = '{data: b, addr: ud_base + 7'd1};
                    cnt           = cnt + 4'd1;
                end
                else
                begin
                    lst_next[cnt] = '{data: b, addr: ud_base + {6'd0, u}};
                    cnt           = cnt + 4'd1;
                end
            end
            MODE_DMA_START:
            begin
                if (mw_reg[u] != 16'd0)
                begin
                    lst_next[cnt] = '{data: pick_byte(mw_reg[u], clk50_reg), addr: pio_addr};
                    cnt           = cnt + 4'd1;
                end
                else if ((ud_reg[u] != 16'd0) && rev_reg)
                begin
                    b = pick_byte(ud_reg[u], clk50_reg);
                    lst_next[cnt] = '{data: b, addr: ud_base};
                    cnt           = cnt + 4'd1;
                    lst_next[cnt] = '{data: b, addr: ud_base + 7'd1};
                    cnt           = cnt + 4'd1;
                end
            end
            MODE_DMA_END:
            begin
                if (mw_reg[u] != 16'd0)
                begin
                    lst_next[cnt] = '{data: pick_byte(pio_reg[u], clk50_reg), addr: pio_addr};
                    cnt           = cnt + 4'd1;
                end
            end
            default:
            begin
            end
        endcase

        n_next = cnt;
    end

    // Input register and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            rd_reg       <= 4'd0;
            n_reg        <= 4'd0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (load)
            begin
                in_valid_reg <= 1'b0;
            end
            if (load)
            begin
                rd_reg <= 4'd0;
                n_reg  <= n_next;
            end
            else if (pop)
            begin
                rd_reg <= rd_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg <= event_t'(s_tdata[$bits(event_t)-1:0]);
        end
        if (load)
        begin
            lst_reg <= lst_next;
        end
    end

    // Channel state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg    <= 1'b0;
            rev_reg   <= 1'b0;
            ctrl_reg  <= 8'd0;
            clk50_reg <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                wants_reg[i] <= {PRIO_NONE, WANT_ANY};
                pio_reg[i]   <= 16'd0;
                mw_reg[i]    <= 16'd0;
                ud_reg[i]    <= 16'd0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CHANNEL:
                begin
                    ch_reg <= cfg_data[0];
                end
                CFG_REV10:
                begin
                    rev_reg <= cfg_data[0];
                end
                CFG_CTRL_INIT:
                begin
                    ctrl_reg  <= cfg_data;
                    clk50_reg <= ch_reg ? cfg_data[2] : cfg_data[1];
                end
                default:
                begin
                end
            endcase
        end
        else if (load)
        begin
            ctrl_reg   <= ctrl_next;
            clk50_reg  <= clk50_next;
            wants_reg  <= wants_next;
            pio_reg    <= pio_next;
            mw_reg     <= mw_next;
            ud_reg     <= ud_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_ide_timing_clock_selector_unit.sv @@
`default_nettype none

// Self-checking bench for the IDE timing and clock selector.
//
// Event items are queued by the stimulus process and presented on the slave
// stream by a driver that changes its outputs on the falling edge. A checker
// on the rising edge keeps its own copy of the channel state (control byte,
// clock choice, per-drive priority, clock want and timing words). For every
// event item it accepts, it works out the config byte writes the event should
// cause. Each write item seen on the master stream is compared with the oldest
// outstanding prediction.
module tb_ide_timing_clock_selector_unit;

    import itcs_pkg::*;

    // Index 3 is not a register; writes to it must leave everything alone.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned SETTLE_CYCLES    = 8;
    localparam int unsigned SINK_HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_EVENTS    = 90;

    // One predicted config byte write.
    typedef struct packed {
        logic [6:0] addr;
        logic [7:0] data;
        logic       last;
    } byte_write_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    // [2:0] mode, [3] unit, [6:4] level, [7] pair_present, [10:8] pair_best_pio
    logic [IN_W-1:0]     s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    // [6:0] write_addr, [14:7] write_data
    logic [OUT_W-1:0]    m_tdata;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = CFG_CHANNEL;
    logic [7:0]          cfg_data  = 8'h00;

    // Stimulus bookkeeping.
    event_t              event_feed[$];
    byte_write_t         expected_writes[$];
    int unsigned         items_queued   = 0;
    int unsigned         items_taken    = 0;
    int unsigned         mismatches     = 0;
    logic                s_taken        = 1'b0;
    int unsigned         sender_idle_pct = 15;
    int unsigned         sink_idle_pct   = 87;
    logic                squeeze_sink   = 1'b0;
    logic                sink_held      = 1'b0;

    // Shadow of the channel state.
    logic                chan_sel;
    logic                paired_udma;
    logic [7:0]          ctrl_shadow;
    logic                clk_is_50;
    logic [1:0]          drive_prio[2];
    logic [1:0]          drive_clk_want[2];
    logic [15:0]         drive_pio_word[2];
    logic [15:0]         drive_mw_word[2];
    logic [15:0]         drive_ud_word[2];
    int unsigned         writes_this_event;

    wr_t                 seen_write;
    byte_write_t         oldest;

    ide_timing_clock_selector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Timing word in bits 15:0 and clock want in bits 17:16 for a mode that
    // has already been clamped to its legal range.
    function automatic logic [17:0] mode_timing(input logic [2:0] kind, input logic [2:0] lv);
        logic [17:0] entry;
        entry = {WANT_ANY, 16'h3121};
        case (kind)
            MODE_PIO:
                case (lv)
                    3'd0:    entry = {WANT_66, 16'hAA88};
                    3'd1:    entry = {WANT_66, 16'hA382};
                    3'd2:    entry = {WANT_66, 16'hA181};
                    3'd3:    entry = {WANT_66, 16'h3332};
                    default: entry = {WANT_ANY, 16'h3121};
                endcase
            MODE_MWDMA:
                case (lv)
                    3'd0:    entry = {WANT_ANY, 16'h8866};
                    3'd1:    entry = {WANT_66, 16'h3222};
                    default: entry = {WANT_ANY, 16'h3121};
                endcase
            default:
                case (lv)
                    3'd0:    entry = {WANT_ANY, 16'h4433};
                    3'd1:    entry = {WANT_50, 16'h4231};
                    3'd2:    entry = {WANT_ANY, 16'h3121};
                    3'd3:    entry = {WANT_66, 16'h2121};
                    3'd4:    entry = {WANT_66, 16'h1111};
                    3'd5:    entry = {WANT_50, 16'h2211};
                    default: entry = {WANT_66, 16'h1111};
                endcase
        endcase
        return entry;
    endfunction

    // At 50 MHz the low byte of a timing word is used, at 66 MHz the high one.
    function automatic logic [7:0] timing_byte(input logic [15:0] word);
        return clk_is_50 ? word[7:0] : word[15:8];
    endfunction

    function automatic void note_write(input logic [6:0] addr, input logic [7:0] data);
        if (writes_this_event < LIST_DEPTH)
        begin
            expected_writes.push_back({addr, data, 1'b0});
            writes_this_event++;
        end
    endfunction

    function automatic void expect_pio_write(input logic [15:0] word);
        note_write(ADDR_PIO_BASE + {4'd0, chan_sel, 2'b00}, timing_byte(word));
    endfunction

    // With pairing on, both drives' UDMA timing bytes are written together.
    function automatic void expect_udma_write(input logic u, input logic [15:0] word);
        logic [6:0] base;
        logic [7:0] value;
        base  = ADDR_UDMA_BASE + {4'd0, chan_sel, 2'b00};
        value = timing_byte(word);
        if (!paired_udma)
            note_write(base + {6'd0, u}, value);
        else
        begin
            note_write(base, value);
            note_write(base + 7'd1, value);
        end
    endfunction

    // Clock arbitration between the two drives. A change of clock rewrites
    // the control byte and then each UDMA drive's timings (the partner's only
    // when present), since the byte taken from each timing word depends on the clock.
    function automatic void settle_clock(input logic u, input logic pair);
        logic [1:0] winner;
        logic [1:0] other_want;
        logic [7:0] sel_bit;
        logic       partner;
        partner = ~u;
        if (drive_prio[0] > drive_prio[1])
        begin
            winner     = drive_clk_want[0];
            other_want = drive_clk_want[1];
        end
        else
        begin
            winner     = drive_clk_want[1];
            other_want = drive_clk_want[0];
        end
        if (winner == WANT_ANY)
            winner = other_want;
        if (winner == WANT_ANY || winner[0] == clk_is_50)
            return;
        clk_is_50   = winner[0];
        sel_bit     = 8'd1 << (chan_sel + 1);
        ctrl_shadow = clk_is_50 ? (ctrl_shadow | sel_bit) : (ctrl_shadow & ~sel_bit);
        note_write(ADDR_CTRL, ctrl_shadow);
        if (pair && drive_ud_word[partner] != 16'h0000)
        begin
            expect_udma_write(partner, drive_ud_word[partner]);
            expect_pio_write(drive_pio_word[partner]);
        end
        if (drive_ud_word[u] != 16'h0000)
        begin
            expect_udma_write(u, drive_ud_word[u]);
            expect_pio_write(drive_pio_word[u]);
        end
    endfunction

    // Updates the shadow state for one accepted event item and queues the
    // writes it causes, the final one flagged as the end of the run.
    function automatic void predict_event(input event_t ev);
        logic [2:0]  lv;
        logic [2:0]  pbest;
        logic [17:0] entry;
        logic        u;
        byte_write_t tail;
        lv    = ev.level;
        pbest = ev.pair_best_pio;
        u     = ev.unit;
        writes_this_event = 0;
        case (ev.mode)
            MODE_PIO:
            begin
                // Out-of-range levels clamp to the top mode; a slower drive
                // on the same cable pulls the PIO mode down to its own.
                if (lv > 3'd4)
                    lv = 3'd4;
                if (pbest > 3'd4)
                    pbest = 3'd4;
                if (ev.pair_present && pbest < lv)
                    lv = pbest;
                entry             = mode_timing(MODE_PIO, lv);
                drive_prio[u]     = PRIO_PIO;
                drive_clk_want[u] = entry[17:16];
                drive_pio_word[u] = entry[15:0];
                settle_clock(u, ev.pair_present);
                expect_pio_write(drive_pio_word[u]);
            end
            MODE_MWDMA:
            begin
                if (lv > 3'd2)
                    lv = 3'd2;
                entry             = mode_timing(MODE_MWDMA, lv);
                drive_prio[u]     = PRIO_MWDMA;
                drive_clk_want[u] = entry[17:16];
                drive_mw_word[u]  = entry[15:0];
                drive_ud_word[u]  = 16'h0000;
                if (paired_udma)
                    ctrl_shadow |= chan_sel ? CH1_UDMA_BITS : CH0_UDMA_BITS;
                else
                    ctrl_shadow |= 8'd1 << (3 + 2 * chan_sel + u);
                note_write(ADDR_CTRL, ctrl_shadow);
                settle_clock(u, ev.pair_present);
            end
            MODE_UDMA:
            begin
                if (lv > 3'd6)
                    lv = 3'd6;
                entry             = mode_timing(MODE_UDMA, lv);
                drive_prio[u]     = PRIO_UDMA;
                drive_clk_want[u] = entry[17:16];
                drive_mw_word[u]  = 16'h0000;
                drive_ud_word[u]  = entry[15:0];
                // The two fastest UDMA modes carry extra bits in both bytes.
                if (lv >= 3'd5)
                    drive_ud_word[u] |= UD_FAST_MASK;
                if (paired_udma)
                    ctrl_shadow &= chan_sel ? CH1_UDMA_KEEP : CH0_UDMA_KEEP;
                else
                    ctrl_shadow &= ~(8'd1 << (3 + 2 * chan_sel + u));
                note_write(ADDR_CTRL, ctrl_shadow);
                settle_clock(u, ev.pair_present);
                expect_udma_write(u, drive_ud_word[u]);
            end
            MODE_DMA_START:
            begin
                // MWDMA borrows the PIO timing register for the transfer.
                if (drive_mw_word[u] != 16'h0000)
                    expect_pio_write(drive_mw_word[u]);
                else if (drive_ud_word[u] != 16'h0000 && paired_udma)
                    expect_udma_write(u, drive_ud_word[u]);
            end
            MODE_DMA_END:
            begin
                if (drive_mw_word[u] != 16'h0000)
                    expect_pio_write(drive_pio_word[u]);
            end
            default:
            begin
                // Unused event codes are ignored altogether.
            end
        endcase
        if (writes_this_event > 0)
        begin
            tail      = expected_writes.pop_back();
            tail.last = 1'b1;
            expected_writes.push_back(tail);
        end
    endfunction

    // A ctrl_init write takes its clock bit from the channel selected at the
    // time, so the channel must be written first when both change.
    function automatic void apply_register(input logic [1:0] idx, input logic [7:0] value);
        case (idx)
            CFG_CHANNEL:   chan_sel = value[0];
            CFG_REV10:     paired_udma = value[0];
            CFG_CTRL_INIT:
            begin
                ctrl_shadow = value;
                clk_is_50   = value[chan_sel + 1];
            end
            default:
            begin
            end
        endcase
    endfunction

    // Checker and predictor. Outputs are compared before the item accepted
    // on the same edge is predicted, although that item cannot produce a
    // write until later in any case.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            chan_sel    = 1'b0;
            paired_udma = 1'b0;
            ctrl_shadow = 8'h00;
            clk_is_50   = 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                drive_prio[i]     = PRIO_NONE;
                drive_clk_want[i] = WANT_ANY;
                drive_pio_word[i] = 16'h0000;
                drive_mw_word[i]  = 16'h0000;
                drive_ud_word[i]  = 16'h0000;
            end
            expected_writes.delete();
            s_taken <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (m_tvalid && m_tready)
            begin
                seen_write = m_tdata[$bits(wr_t)-1:0];
                if (expected_writes.size() == 0)
                begin
                    $error("unexpected write item: write_addr 0x%02h write_data 0x%02h",
                           seen_write.addr, seen_write.data);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_writes.pop_front();
                    if (seen_write.addr !== oldest.addr)
                    begin
                        $error("write_addr: expected 0x%02h, actual 0x%02h",
                               oldest.addr, seen_write.addr);
                        mismatches++;
                    end
                    if (seen_write.data !== oldest.data)
                    begin
                        $error("write_data: expected 0x%02h, actual 0x%02h",
                               oldest.data, seen_write.data);
                        mismatches++;
                    end
                    if (m_tlast !== oldest.last)
                    begin
                        $error("last: expected %0b, actual %0b", oldest.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            s_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                predict_event(s_tdata[$bits(event_t)-1:0]);
                items_taken++;
            end
        end
    end

    // Event driver. A presented item is held until it has been taken; the
    // next one is then offered at once or after a random pause.
    always @(negedge clk)
    begin
        if (!s_tvalid || s_taken)
        begin
            if (event_feed.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= IN_W'(event_feed.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Write sink with random back-pressure, or none at all while held off.
    always @(negedge clk)
        m_tready <= !sink_held && ($urandom_range(0, 99) >= sink_idle_pct);

    // Long hold-off of the sink, so that the block fills up and has to stall
    // its event input while items keep being offered.
    initial
    begin : sink_pressure
        wait (squeeze_sink);
        @(negedge clk);
        sink_held <= 1'b1;
        repeat (SINK_HOLD_CYCLES) @(negedge clk);
        sink_held <= 1'b0;
    end

    // Overall time limit for the run.
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic offer(input logic [2:0] mode, input logic u, input logic [2:0] lv,
                         input logic pair, input logic [2:0] pbest);
        event_t ev;
        ev.mode          = mode;
        ev.unit          = u;
        ev.level         = lv;
        ev.pair_present  = pair;
        ev.pair_best_pio = pbest;
        event_feed.push_back(ev);
        items_queued++;
    endtask

    // Queues random events. Mostly real events with random content, with a
    // few unused codes thrown in; only the real events count towards the
    // total asked for.
    task automatic queue_random(input int unsigned count);
        int unsigned real_events;
        logic [2:0]  mode;
        real_events = 0;
        @(posedge clk);
        while (real_events < count)
        begin
            if ($urandom_range(0, 99) < 8)
                mode = 3'($urandom_range(5, 7));
            else
            begin
                mode = 3'($urandom_range(0, 4));
                real_events++;
            end
            offer(mode, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
        end
    endtask

    // Waits until every queued item has been taken and every predicted write
    // has arrived, then lets the block finish any event with no writes.
    task automatic drain();
        @(negedge clk);
        while (items_taken != items_queued || expected_writes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Channel 0, no pairing, control byte clear; a write to the unused
        // index must change nothing.
        cfg_write(CFG_CHANNEL, 8'h00);
        cfg_write(CFG_REV10, 8'h00);
        cfg_write(CFG_CTRL_INIT, 8'h00);
        cfg_write(CFG_UNUSED, 8'hA5);

        // Directed events: every event kind on both drives, levels at and
        // beyond the top of each range, PIO trimmed by a slower partner,
        // clock changes with UDMA drives present, DMA start and end with and
        // without DMA set up, and the unused event codes.
        @(posedge clk);
        offer(MODE_PIO,       1'b0, 3'd0, 1'b0, 3'd0);
        offer(MODE_PIO,       1'b1, 3'd7, 1'b1, 3'd7);
        offer(MODE_PIO,       1'b0, 3'd4, 1'b1, 3'd2);
        offer(MODE_DMA_START, 1'b0, 3'd0, 1'b0, 3'd0);
        offer(MODE_DMA_END,   1'b1, 3'd0, 1'b0, 3'd0);
        offer(MODE_MWDMA,     1'b0, 3'd1, 1'b0, 3'd0);
        offer(MODE_MWDMA,     1'b1, 3'd7, 1'b1, 3'd4);
        offer(MODE_DMA_START, 1'b0, 3'd3, 1'b1, 3'd1);
        offer(MODE_DMA_END,   1'b0, 3'd5, 1'b0, 3'd6);
        offer(MODE_DMA_START, 1'b1, 3'd0, 1'b1, 3'd0);
        offer(MODE_UDMA,      1'b0, 3'd1, 1'b0, 3'd0);
        offer(MODE_UDMA,      1'b1, 3'd5, 1'b1, 3'd3);
        offer(MODE_UDMA,      1'b0, 3'd7, 1'b1, 3'd7);
        offer(MODE_UDMA,      1'b1, 3'd0, 1'b1, 3'd0);
        offer(MODE_DMA_START, 1'b0, 3'd0, 1'b0, 3'd0);
        offer(MODE_DMA_END,   1'b1, 3'd0, 1'b0, 3'd0);
        offer(3'd5,           1'b1, 3'd7, 1'b1, 3'd7);
        offer(3'd6,           1'b0, 3'd0, 1'b0, 3'd0);
        offer(3'd7,           1'b1, 3'd2, 1'b0, 3'd5);
        offer(MODE_PIO,       1'b1, 3'd3, 1'b0, 3'd4);
        offer(MODE_MWDMA,     1'b0, 3'd0, 1'b1, 3'd0);
        offer(MODE_UDMA,      1'b1, 3'd3, 1'b1, 3'd4);
        offer(MODE_UDMA,      1'b0, 3'd6, 1'b1, 3'd1);
        drain();

        // Channel 1 with pairing and every control bit set.
        cfg_write(CFG_CHANNEL, 8'h01);
        cfg_write(CFG_REV10, 8'h01);
        cfg_write(CFG_CTRL_INIT, 8'hFF);
        queue_random(RANDOM_EVENTS);
        drain();

        // Sender mostly idle, sink mostly ready.
        sender_idle_pct = 87;
        sink_idle_pct   = 15;
        cfg_write(CFG_CHANNEL, 8'hFE);
        cfg_write(CFG_REV10, 8'hFF);
        cfg_write(CFG_CTRL_INIT, 8'($urandom_range(0, 255)));
        queue_random(RANDOM_EVENTS);
        drain();

        // Full rate on both sides, with the sink held off for a while.
        sender_idle_pct = 0;
        sink_idle_pct   = 0;
        cfg_write(CFG_CHANNEL, 8'h01);
        cfg_write(CFG_REV10, 8'h00);
        cfg_write(CFG_CTRL_INIT, 8'($urandom_range(0, 255)));
        queue_random(RANDOM_EVENTS);
        squeeze_sink = 1'b1;
        drain();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
